@@ rtl/sbus_pkg.sv @@
`timescale 1ns / 1ps

package sbus_pkg;

    // Frame layout and decoding constants.
    localparam int FRAME_BYTES     = 25;
    localparam int OUT_CHANNELS    = 18;
    localparam int ANALOG_CHANNELS = 16;
    localparam int FIELD_BITS      = 11;
    localparam int FRAME_W         = FRAME_BYTES * 8;
    localparam int POS_W           = 5;
    localparam int CHAN_W          = 5;
    localparam int CFG_W           = 16;

    localparam logic [7:0]       SYNC_BYTE   = 8'h0F;
    localparam logic [11:0]      DUTY_OFFSET = 12'd880;
    localparam logic [CFG_W-1:0] GAP_RESET   = 16'd175;
    localparam logic [CFG_W-1:0] MAX_RESET   = 16'd2000;
    localparam logic [CFG_W-1:0] MIN_RESET   = 16'd1000;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GAP_LIMIT = 2'd0,
        CFG_SERVO_MAX = 2'd1,
        CFG_SERVO_MIN = 2'd2
    } t_cfg_index;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } t_state;

    // One received byte with its arrival tick.
    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_tick;
    } t_in_item;

    // One decoded channel result.
    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [15:0]       duty;
        logic [31:0]       stamp;
        logic              last;
    } t_out_item;

    // Control from the sequencer to the frame shift line.
    typedef struct packed {
        logic       load;
        logic       shift;
        logic [7:0] data;
    } t_frame_ctl;

endpackage

@@ rtl/sbus_frame_decoder.sv @@
`timescale 1ns / 1ps

// Serial bus frame decoder.
// Input channel: one received byte and its arrival tick per item, taken when
// i_in_valid is high and o_in_stall is low. Bytes are gathered into 25-byte
// frames opened by the sync byte; a byte that arrives too long after the
// frame start restarts assembly, and a non-sync byte at the frame start is
// dropped. Every byte that does not complete a frame is taken without a stall.
// When the 25th byte is taken, the block stalls its input and sends 18
// channel items, one per cycle while the receiver does not stall, through a
// single output register; the first is presented once the sequencer has
// entered its emit state and loaded it there. When the receiver never stalls,
// the last is taken at the first edge at which the next byte can be taken.
// The sequencer and the frame shift line decode one channel field per cycle.
// A stall on the output channel simply holds the current item and pauses the
// sequencer. Configuration writes (gap limit, servo maximum and minimum) are
// taken at any edge with i_cfg_we high outside reset. Reset empties the output
// register, clears the frame position and start tick and loads the register defaults.
module sbus_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sbus_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sbus_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [sbus_pkg::CFG_W-1:0]    i_cfg_data
);

    sbus_pkg::t_state r_state, n_state;
    logic [sbus_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [31:0]                 r_start, n_start;
    logic [31:0]                 r_stamp, n_stamp;
    logic [sbus_pkg::CHAN_W-1:0] r_ch, n_ch;
    logic [sbus_pkg::CFG_W-1:0]  r_gap, r_smax, r_smin;

    sbus_pkg::t_frame_ctl        frame_ctl;
    sbus_pkg::t_out_item         issue_item;
    logic [sbus_pkg::FIELD_BITS-1:0] field;
    logic [1:0]                  flags;
    logic [15:0]                 duty;
    logic [31:0]                 elapsed;
    logic [sbus_pkg::POS_W-1:0]  pos_eff;
    logic                        in_acc, issue, out_ready, analog, flag, last_ch;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap  <= sbus_pkg::GAP_RESET;
            r_smax <= sbus_pkg::MAX_RESET;
            r_smin <= sbus_pkg::MIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sbus_pkg::CFG_GAP_LIMIT: r_gap  <= i_cfg_data;
                sbus_pkg::CFG_SERVO_MAX: r_smax <= i_cfg_data;
                sbus_pkg::CFG_SERVO_MIN: r_smin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbus_pkg::ST_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_ch    <= n_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp <= n_stamp;
    end

    assign o_in_stall = (r_state != sbus_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Digital channels pick their flag bit from the byte left at bits 15:8 (byte 23).
    assign analog  = (r_ch < sbus_pkg::CHAN_W'(sbus_pkg::ANALOG_CHANNELS));
    assign flag    = (r_ch == sbus_pkg::CHAN_W'(sbus_pkg::ANALOG_CHANNELS)) ? flags[0]
                                                                             : flags[1];
    assign last_ch = (r_ch == sbus_pkg::CHAN_W'(sbus_pkg::OUT_CHANNELS - 1));

    // Frame assembly on input items and channel emission afterwards.
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_start   = r_start;
        n_stamp   = r_stamp;
        n_ch      = r_ch;
        issue     = 1'b0;
        frame_ctl = '0;
        frame_ctl.data = i_in_item.rx_byte;

        elapsed = i_in_item.time_tick - r_start;
        if ((r_pos >= sbus_pkg::POS_W'(sbus_pkg::FRAME_BYTES)) ||
            (elapsed > {16'h0000, r_gap})) begin
            pos_eff = '0;
        end else begin
            pos_eff = r_pos;
        end

        unique case (r_state)
            sbus_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if ((pos_eff == '0) && (i_in_item.rx_byte != sbus_pkg::SYNC_BYTE)) begin
                        n_pos = '0;
                    end else begin
                        frame_ctl.load = 1'b1;
                        if (pos_eff == '0) begin
                            n_start = i_in_item.time_tick;
                        end
                        if (pos_eff == sbus_pkg::POS_W'(sbus_pkg::FRAME_BYTES - 1)) begin
                            n_pos   = '0;
                            n_stamp = i_in_item.time_tick;
                            n_ch    = '0;
                            n_state = sbus_pkg::ST_EMIT;
                        end else begin
                            n_pos = pos_eff + 1'b1;
                        end
                    end
                end
            end
            sbus_pkg::ST_EMIT: begin
                if (out_ready) begin
                    issue           = 1'b1;
                    frame_ctl.shift = analog;
                    if (last_ch) begin
                        n_state = sbus_pkg::ST_IDLE;
                    end else begin
                        n_ch = r_ch + 1'b1;
                    end
                end
            end
            default: n_state = sbus_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        issue_item.channel = r_ch;
        issue_item.duty    = duty;
        issue_item.stamp   = r_stamp;
        issue_item.last    = last_ch;
    end

    sbus_frame_shift u_frame (
        .i_clk   (i_clk),
        .i_ctl   (frame_ctl),
        .o_field (field),
        .o_flags (flags)
    );

    sbus_duty_unit u_duty (
        .i_field     (field),
        .i_analog    (analog),
        .i_flag      (flag),
        .i_servo_max (r_smax),
        .i_servo_min (r_smin),
        .o_duty      (duty)
    );

    sbus_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (issue),
        .i_item  (issue_item),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

@@ rtl/sbus_frame_shift.sv @@
`timescale 1ns / 1ps

module sbus_frame_shift (
    input  logic                                 i_clk,
    input  sbus_pkg::t_frame_ctl                 i_ctl,
    output logic [sbus_pkg::FIELD_BITS-1:0]      o_field,
    output logic [1:0]                           o_flags
);

    logic [sbus_pkg::FRAME_W-1:0] r_frame;

    // Bytes enter at the top, so after a full frame byte k sits at bits 8k+7..8k.
    // During decoding the line moves down by one field per analogue channel,
    // which leaves the flag byte (byte 23) at bits 15:8 at the end.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_frame <= {i_ctl.data, r_frame[sbus_pkg::FRAME_W-1:8]};
        end else if (i_ctl.shift) begin
            r_frame <= {{sbus_pkg::FIELD_BITS{1'b0}},
                        r_frame[sbus_pkg::FRAME_W-1:sbus_pkg::FIELD_BITS]};
        end
    end

    assign o_field = r_frame[8 +: sbus_pkg::FIELD_BITS];
    assign o_flags = r_frame[9:8];

endmodule

@@ rtl/sbus_duty_unit.sv @@
`timescale 1ns / 1ps

module sbus_duty_unit (
    input  logic [sbus_pkg::FIELD_BITS-1:0] i_field,
    input  logic                            i_analog,
    input  logic                            i_flag,
    input  logic [sbus_pkg::CFG_W-1:0]      i_servo_max,
    input  logic [sbus_pkg::CFG_W-1:0]      i_servo_min,
    output logic [15:0]                     o_duty
);

    logic [13:0] times5;
    logic [11:0] scaled;

    // Analogue map: floor(5 * v / 8) + 880, built from a shift and two adds.
    always_comb begin
        times5 = {1'b0, i_field, 2'b00} + {3'b000, i_field};
        scaled = {1'b0, times5[13:3]} + sbus_pkg::DUTY_OFFSET;
        if (i_analog) begin
            o_duty = {4'b0000, scaled};
        end else if (i_flag) begin
            o_duty = i_servo_max;
        end else begin
            o_duty = i_servo_min;
        end
    end

endmodule

@@ rtl/sbus_out_reg.sv @@
`timescale 1ns / 1ps

module sbus_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  sbus_pkg::t_out_item i_item,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_stall,
    output sbus_pkg::t_out_item o_item
);

    logic                r_valid;
    sbus_pkg::t_out_item r_item;

    // Space is free when the register is empty or its item leaves this cycle.
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
